FILE: hw/rtl/vcci_pkg.sv
// ----------------------------------------------------------------------------
// vcci_pkg
// Shared types and constants for the display controller command port.
// ----------------------------------------------------------------------------
package vcci_pkg;

  localparam int RAM_DEPTH_DEF = 48;
  localparam int KEY_BYTES_DEF = 6;

  localparam int ADDR_W = 6;
  localparam int BYTE_W = 8;
  localparam int SLOT_W = 3;
  localparam int FUNC_W = 2;

  // bus function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_KEY   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd3;

  // command byte top bits
  localparam logic [1:0] CMD_MODE = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_DISP = 2'd2;
  localparam logic [1:0] CMD_ADDR = 2'd3;

  // frame kinds
  localparam logic [1:0] FRAME_NONE = 2'd0;
  localparam logic [1:0] FRAME_ADDR = 2'd1;
  localparam logic [1:0] FRAME_KEY  = 2'd2;

  localparam logic [SLOT_W-1:0] KEY_PTR_MAX = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CMD,
    OP_DATA,
    OP_READ,
    OP_KEY,
    OP_FETCH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] value;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] faddr;
  } item_t;

endpackage

FILE: hw/rtl/vfd_controller_command_interface_unit.sv
// Result beats are registered: an accepted input beat goes through the queue
// and then the result registers; a display fetch also through the RAM read.
// Throughput: one beat per cycle while results are not stalled; a display fetch
// holds the engine in its fetch state, as the display RAM read is registered.
// Reset (rst, synchronous): clears all mode, pointer and key state, the queue,
// and the per-entry written bits of the display RAM, so it reads as zero.
// ----------------------------------------------------------------------------
// vfd_controller_command_interface_unit
// Display controller serial command port: classifier, queue, execution engine.
// ----------------------------------------------------------------------------
module vfd_controller_command_interface_unit #(
  parameter int RAM_DEPTH = vcci_pkg::RAM_DEPTH_DEF,
  parameter int KEY_BYTES = vcci_pkg::KEY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [vcci_pkg::FUNC_W-1:0]   func,
  input  logic                          frame_start,
  input  logic [vcci_pkg::BYTE_W-1:0]   byte_value,
  input  logic [vcci_pkg::SLOT_W-1:0]   key_slot,
  input  logic [vcci_pkg::ADDR_W-1:0]   fetch_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vcci_pkg::BYTE_W-1:0]   read_data,
  output logic                          ram_write,
  output logic [vcci_pkg::ADDR_W-1:0]   ram_address,
  output logic [vcci_pkg::BYTE_W-1:0]   ram_data,
  output logic                          display_enabled,
  output logic [2:0]                    brightness,
  output logic [3:0]                    display_mode,
  output logic                          test_mode
);

  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  vcci_pkg::item_t push_item;
  vcci_pkg::item_t head;

  vcci_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .frame_start   (frame_start),
    .byte_value    (byte_value),
    .key_slot      (key_slot),
    .fetch_address (fetch_address),
    .push          (push),
    .item          (push_item),
    .q_full        (q_full)
  );

  vcci_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  vcci_back #(
    .RAM_DEPTH (RAM_DEPTH),
    .KEY_BYTES (KEY_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .item            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_data       (read_data),
    .ram_write       (ram_write),
    .ram_address     (ram_address),
    .ram_data        (ram_data),
    .display_enabled (display_enabled),
    .brightness      (brightness),
    .display_mode    (display_mode),
    .test_mode       (test_mode)
  );

endmodule

FILE: hw/rtl/vcci_ram.sv
// ----------------------------------------------------------------------------
// vcci_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vcci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/vcci_front.sv
// ----------------------------------------------------------------------------
// vcci_front
// Accepts bus, key scan and fetch beats and classifies them into operations.
// ----------------------------------------------------------------------------
module vcci_front (
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [vcci_pkg::FUNC_W-1:0]    func,
  input  logic                           frame_start,
  input  logic [vcci_pkg::BYTE_W-1:0]    byte_value,
  input  logic [vcci_pkg::SLOT_W-1:0]    key_slot,
  input  logic [vcci_pkg::ADDR_W-1:0]    fetch_address,
  output logic                           push,
  output vcci_pkg::item_t                item,
  input  logic                           q_full
);

  vcci_pkg::op_t op;

  always_comb begin
    case (func)
      vcci_pkg::FUNC_WRITE: op = frame_start ? vcci_pkg::OP_CMD : vcci_pkg::OP_DATA;
      // a read carrying the frame start flag does nothing
      vcci_pkg::FUNC_READ:  op = frame_start ? vcci_pkg::OP_NOP : vcci_pkg::OP_READ;
      vcci_pkg::FUNC_KEY:   op = vcci_pkg::OP_KEY;
      vcci_pkg::FUNC_FETCH: op = vcci_pkg::OP_FETCH;
      default:              op = vcci_pkg::OP_NOP;
    endcase
  end

  assign in_stall   = q_full;
  assign push       = in_valid && !q_full;
  assign item.op    = op;
  assign item.value = byte_value;
  assign item.slot  = key_slot;
  assign item.faddr = fetch_address;

endmodule

FILE: hw/rtl/vcci_queue.sv
// ----------------------------------------------------------------------------
// vcci_queue
// Two-entry queue decoupling the classifier from the execution engine.
// ----------------------------------------------------------------------------
module vcci_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vcci_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output vcci_pkg::item_t head
);

  vcci_pkg::item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/vcci_back.sv
// ----------------------------------------------------------------------------
// vcci_back
// Execution engine: command decode, display RAM, key store and result beat.
// ----------------------------------------------------------------------------
module vcci_back #(
  parameter int RAM_DEPTH = vcci_pkg::RAM_DEPTH_DEF,
  parameter int KEY_BYTES = vcci_pkg::KEY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  vcci_pkg::item_t               item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vcci_pkg::BYTE_W-1:0]   read_data,
  output logic                          ram_write,
  output logic [vcci_pkg::ADDR_W-1:0]   ram_address,
  output logic [vcci_pkg::BYTE_W-1:0]   ram_data,
  output logic                          display_enabled,
  output logic [2:0]                    brightness,
  output logic [3:0]                    display_mode,
  output logic                          test_mode
);

  localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [vcci_pkg::ADDR_W:0] RAM_LIMIT = (vcci_pkg::ADDR_W+1)'(RAM_DEPTH);
  localparam logic [vcci_pkg::SLOT_W:0] KEY_LIMIT = (vcci_pkg::SLOT_W+1)'(KEY_BYTES);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FETCH = 2'b10
  } bstate_t;

  bstate_t state;

  // control state
  logic [vcci_pkg::ADDR_W-1:0] ptr, ptr_next;
  logic                        fixed, fixed_next;
  logic [vcci_pkg::SLOT_W-1:0] kptr, kptr_next;
  logic [1:0]                  frame, frame_next;
  logic [3:0]                  mode, mode_next;
  logic                        on, on_next;
  logic [2:0]                  dim, dim_next;
  logic                        test, test_next;
  logic [vcci_pkg::BYTE_W-1:0] kstore [KEY_BYTES];
  logic [RAM_DEPTH-1:0]        ram_valid;
  logic                        fetch_hit;

  // per-item results
  logic                        go;
  logic                        go_fetch;
  logic [vcci_pkg::BYTE_W-1:0] rd;
  logic                        wr;
  logic [vcci_pkg::ADDR_W-1:0] wa;
  logic                        key_we;
  logic [vcci_pkg::BYTE_W-1:0] ram_rdata;

  assign go  = q_valid && (state == ST_RUN) && (!out_valid || !out_stall);
  assign pop = go;

  always_comb begin
    ptr_next   = ptr;
    fixed_next = fixed;
    kptr_next  = kptr;
    frame_next = frame;
    mode_next  = mode;
    on_next    = on;
    dim_next   = dim;
    test_next  = test;
    rd         = '0;
    wr         = 1'b0;
    wa         = '0;
    key_we     = 1'b0;
    go_fetch   = 1'b0;
    case (item.op)
      vcci_pkg::OP_CMD: begin
        case (item.value[7:6])
          vcci_pkg::CMD_MODE: begin
            mode_next  = item.value[3:0];
            frame_next = vcci_pkg::FRAME_NONE;
          end
          vcci_pkg::CMD_DATA: begin
            fixed_next = item.value[2];
            test_next  = item.value[3];
            if (item.value[1]) begin
              frame_next = vcci_pkg::FRAME_KEY;
              kptr_next  = '0;
            end else begin
              frame_next = vcci_pkg::FRAME_NONE;
            end
          end
          vcci_pkg::CMD_DISP: begin
            on_next    = item.value[3];
            dim_next   = item.value[2:0];
            frame_next = vcci_pkg::FRAME_NONE;
          end
          default: begin
            ptr_next   = item.value[vcci_pkg::ADDR_W-1:0];
            frame_next = vcci_pkg::FRAME_ADDR;
          end
        endcase
      end
      vcci_pkg::OP_DATA: begin
        if (frame == vcci_pkg::FRAME_ADDR) begin
          // writes past the RAM are dropped but the pointer still moves unless fixed
          if ({1'b0, ptr} < RAM_LIMIT) begin
            wr = 1'b1;
            wa = ptr;
          end
          if (!fixed) begin
            ptr_next = ptr + vcci_pkg::ADDR_W'(1);
          end
        end
      end
      vcci_pkg::OP_READ: begin
        if (frame == vcci_pkg::FRAME_KEY) begin
          if ({1'b0, kptr} < KEY_LIMIT) begin
            rd = kstore[kptr[KW-1:0]];
          end
          if (kptr != vcci_pkg::KEY_PTR_MAX) begin
            kptr_next = kptr + vcci_pkg::SLOT_W'(1);
          end
        end
      end
      vcci_pkg::OP_KEY: begin
        key_we = ({1'b0, item.slot} < KEY_LIMIT);
      end
      vcci_pkg::OP_FETCH: begin
        go_fetch = 1'b1;
      end
      default: begin
      end
    endcase
  end

  vcci_ram #(
    .WIDTH (vcci_pkg::BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (go && wr),
    .waddr (wa[AW-1:0]),
    .wdata (item.value),
    .raddr (item.faddr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      ptr       <= '0;
      fixed     <= 1'b0;
      kptr      <= '0;
      frame     <= vcci_pkg::FRAME_NONE;
      mode      <= '0;
      on        <= 1'b0;
      dim       <= '0;
      test      <= 1'b0;
      ram_valid <= '0;
      fetch_hit <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
        kstore[i] <= '0;
      end
    end else begin
      if (go) begin
        ptr   <= ptr_next;
        fixed <= fixed_next;
        kptr  <= kptr_next;
        frame <= frame_next;
        mode  <= mode_next;
        on    <= on_next;
        dim   <= dim_next;
        test  <= test_next;
        if (wr) begin
          ram_valid[wa[AW-1:0]] <= 1'b1;
        end
        if (key_we) begin
          kstore[item.slot[KW-1:0]] <= item.value;
        end
      end
      // unwritten or out-of-range entries read as zero
      fetch_hit <= ({1'b0, item.faddr} < RAM_LIMIT) && ram_valid[item.faddr[AW-1:0]];
      case (state)
        ST_RUN: begin
          if (go && go_fetch) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
      if ((go && !go_fetch) || state == ST_FETCH) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (go && !go_fetch) begin
      read_data   <= rd;
      ram_write   <= wr;
      ram_address <= wa;
      ram_data    <= wr ? item.value : '0;
    end else if (state == ST_FETCH) begin
      read_data   <= fetch_hit ? ram_rdata : '0;
      ram_write   <= 1'b0;
      ram_address <= '0;
      ram_data    <= '0;
    end
  end

  // state only moves when a new beat is loaded, so these track the held beat
  assign display_enabled = on;
  assign brightness      = dim;
  assign display_mode    = mode;
  assign test_mode       = test;

endmodule

FILE: hw/rtl/vcci_checker.sv
// ----------------------------------------------------------------------------
// vcci_checker
// Port-level checks on the command port result beats, bound to the top level.
// ----------------------------------------------------------------------------
module vcci_checker #(
  parameter int RAM_DEPTH = vcci_pkg::RAM_DEPTH_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [vcci_pkg::BYTE_W-1:0] read_data,
  input logic                        ram_write,
  input logic [vcci_pkg::ADDR_W-1:0] ram_address,
  input logic [vcci_pkg::BYTE_W-1:0] ram_data,
  input logic                        display_enabled,
  input logic [2:0]                  brightness,
  input logic [3:0]                  display_mode,
  input logic                        test_mode
);

  localparam logic [vcci_pkg::ADDR_W:0] RAM_LIMIT = (vcci_pkg::ADDR_W+1)'(RAM_DEPTH);

  // a stalled result beat holds, including the mode and brightness status fields
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(ram_data)
      && $stable(ram_address) && $stable(display_mode) && $stable(brightness))
    else $error("stalled result beat changed");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && ram_write |-> ({1'b0, ram_address} < RAM_LIMIT) && read_data == '0)
    else $error("ram write outside ram or with read data");

  a_no_wr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ram_write |-> ram_address == '0 && ram_data == '0)
    else $error("write fields set without a ram write");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !display_enabled && brightness == '0
      && display_mode == '0 && !test_mode)
    else $error("state not cleared by reset");

endmodule

bind vfd_controller_command_interface_unit vcci_checker #(
  .RAM_DEPTH (RAM_DEPTH)
) u_vcci_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .read_data       (read_data),
  .ram_write       (ram_write),
  .ram_address     (ram_address),
  .ram_data        (ram_data),
  .display_enabled (display_enabled),
  .brightness      (brightness),
  .display_mode    (display_mode),
  .test_mode       (test_mode)
);

FILE: verif/tb_vfd_controller_command_interface_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vfd_controller_command_interface_unit
// Self-checking bench for the display controller command port. Drives command,
// data, read, key load and fetch beats with random gaps and output stalls,
// predicts every result beat in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
module tb_vfd_controller_command_interface_unit;
  import vcci_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    logic [BYTE_W-1:0] read_data;
    logic              ram_write;
    logic [ADDR_W-1:0] ram_address;
    logic [BYTE_W-1:0] ram_data;
    logic              display_enabled;
    logic [2:0]        brightness;
    logic [3:0]        display_mode;
    logic              test_mode;
  } port_result_t;

  class cmd_port_scoreboard;
    logic [BYTE_W-1:0] ram_image [RAM_DEPTH_DEF];
    logic [BYTE_W-1:0] key_image [KEY_BYTES_DEF];
    logic [ADDR_W-1:0] write_ptr;
    logic              fixed_ptr;
    logic              key_read;
    logic [SLOT_W-1:0] key_ptr;
    logic [3:0]        mode;
    logic              disp_on;
    logic [2:0]        dim;
    logic              test;
    logic [1:0]        frame;
    port_result_t      pending_results[$];
    int                mismatch_count;

    function new();
      foreach (ram_image[i]) ram_image[i] = '0;
      foreach (key_image[i]) key_image[i] = '0;
      write_ptr = '0;
      fixed_ptr = 1'b0;
      key_read = 1'b0;
      key_ptr = '0;
      mode = '0;
      disp_on = 1'b0;
      dim = '0;
      test = 1'b0;
      frame = FRAME_NONE;
      mismatch_count = 0;
    endfunction

    function void apply_command(logic [BYTE_W-1:0] b);
      case (b[7:6])
        CMD_MODE: begin
          mode = b[3:0];
          frame = FRAME_NONE;
        end
        CMD_DATA: begin
          fixed_ptr = b[2];
          key_read = b[1];
          test = b[3];
          if (key_read) begin
            frame = FRAME_KEY;
            key_ptr = '0;
          end else begin
            frame = FRAME_NONE;
          end
        end
        CMD_DISP: begin
          disp_on = b[3];
          dim = b[2:0];
          frame = FRAME_NONE;
        end
        default: begin
          write_ptr = b[5:0];
          frame = FRAME_ADDR;
        end
      endcase
    endfunction

    function void predict_beat(logic [FUNC_W-1:0] fn, logic fs, logic [BYTE_W-1:0] b,
                               logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] faddr);
      port_result_t r;
      r = '{default: '0};
      case (fn)
        FUNC_WRITE: begin
          if (fs) begin
            apply_command(b);
          end else if (frame == FRAME_ADDR) begin
            // writes above the ram are dropped but the pointer still moves unless fixed
            if (write_ptr < RAM_DEPTH_DEF) begin
              ram_image[write_ptr] = b;
              r.ram_write = 1'b1;
              r.ram_address = write_ptr;
              r.ram_data = b;
            end
            if (!fixed_ptr) write_ptr = write_ptr + 1'b1;
          end
        end
        FUNC_READ: begin
          if (!fs && frame == FRAME_KEY) begin
            if (key_ptr < KEY_BYTES_DEF) r.read_data = key_image[key_ptr];
            if (key_ptr != KEY_PTR_MAX) key_ptr = key_ptr + 1'b1;
          end
        end
        FUNC_KEY: begin
          if (slot < KEY_BYTES_DEF) key_image[slot] = b;
        end
        FUNC_FETCH: begin
          if (faddr < RAM_DEPTH_DEF) r.read_data = ram_image[faddr];
        end
      endcase
      r.display_enabled = disp_on;
      r.brightness = dim;
      r.display_mode = mode;
      r.test_mode = test;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_beat(port_result_t got);
      port_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none actual read_data %0h",
                 $time, got.read_data);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("ram_write", want.ram_write, got.ram_write);
      compare_field("ram_address", want.ram_address, got.ram_address);
      compare_field("ram_data", want.ram_data, got.ram_data);
      compare_field("display_enabled", want.display_enabled, got.display_enabled);
      compare_field("brightness", want.brightness, got.brightness);
      compare_field("display_mode", want.display_mode, got.display_mode);
      compare_field("test_mode", want.test_mode, got.test_mode);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [FUNC_W-1:0] func;
  logic              frame_start;
  logic [BYTE_W-1:0] byte_value;
  logic [SLOT_W-1:0] key_slot;
  logic [ADDR_W-1:0] fetch_address;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] read_data;
  logic              ram_write;
  logic [ADDR_W-1:0] ram_address;
  logic [BYTE_W-1:0] ram_data;
  logic              display_enabled;
  logic [2:0]        brightness;
  logic [3:0]        display_mode;
  logic              test_mode;

  cmd_port_scoreboard scoreboard = new();
  int                 beats_sent = 0;
  int                 cycle_count = 0;
  int                 send_run_left = 0;
  bit                 send_quiet = 1'b0;
  int                 recv_run_left = 0;
  bit                 recv_quiet = 1'b0;

  vfd_controller_command_interface_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .frame_start     (frame_start),
    .byte_value      (byte_value),
    .key_slot        (key_slot),
    .fetch_address   (fetch_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_data       (read_data),
    .ram_write       (ram_write),
    .ram_address     (ram_address),
    .ram_data        (ram_data),
    .display_enabled (display_enabled),
    .brightness      (brightness),
    .display_mode    (display_mode),
    .test_mode       (test_mode)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_vfd_controller_command_interface_unit: FAIL");
      $finish;
    end
  end

  // runs with random idle gaps are mixed with stretches of back-to-back beats
  function automatic int draw_idle(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(20, 80);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic fs,
                           input logic [BYTE_W-1:0] b, input logic [SLOT_W-1:0] slot,
                           input logic [ADDR_W-1:0] faddr);
    int gap;
    gap = draw_idle(send_run_left, send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    frame_start <= fs;
    byte_value <= b;
    key_slot <= slot;
    fetch_address <= faddr;
    do @(posedge clk); while (in_stall);
    scoreboard.predict_beat(fn, fs, b, slot, faddr);
    beats_sent++;
  endtask

  task automatic send_cmd(input logic [BYTE_W-1:0] b);
    send_beat(FUNC_WRITE, 1'b1, b, SLOT_W'($urandom), ADDR_W'($urandom));
  endtask

  task automatic send_data(input logic [BYTE_W-1:0] b);
    send_beat(FUNC_WRITE, 1'b0, b, SLOT_W'($urandom), ADDR_W'($urandom));
  endtask

  task automatic send_read(input logic fs);
    send_beat(FUNC_READ, fs, BYTE_W'($urandom), SLOT_W'($urandom), ADDR_W'($urandom));
  endtask

  task automatic send_key(input logic [SLOT_W-1:0] slot, input logic [BYTE_W-1:0] b);
    send_beat(FUNC_KEY, 1'($urandom), b, slot, ADDR_W'($urandom));
  endtask

  task automatic send_fetch(input logic [ADDR_W-1:0] faddr);
    send_beat(FUNC_FETCH, 1'($urandom), BYTE_W'($urandom), SLOT_W'($urandom), faddr);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (scoreboard.pending_results.size() != 0);
  endtask

  // mostly low addresses, some near the top of the ram and the wrap point
  function automatic logic [ADDR_W-1:0] pick_ram_address();
    case ($urandom_range(0, 3))
      0, 1: return ADDR_W'($urandom_range(0, RAM_DEPTH_DEF - 1));
      2: return ADDR_W'($urandom_range(RAM_DEPTH_DEF - 8, 63));
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  task automatic run_random(input int target);
    int stop;
    stop = beats_sent + target;
    while (beats_sent < stop) begin
      case ($urandom_range(0, 6))
        0, 1: begin
          // ram write frame, sometimes with fixed addressing
          if ($urandom_range(0, 2) == 0)
            send_cmd({CMD_DATA, 2'($urandom), 1'($urandom),
                      ($urandom_range(0, 3) == 0), 1'b0, 1'($urandom)});
          send_cmd({CMD_ADDR, pick_ram_address()});
          repeat ($urandom_range(1, 16)) begin
            if ($urandom_range(0, 7) == 0) send_fetch(ADDR_W'($urandom));
            send_data(BYTE_W'($urandom));
          end
        end
        2: begin
          // key scan loads, then a key read frame
          repeat ($urandom_range(0, 4)) send_key(SLOT_W'($urandom), BYTE_W'($urandom));
          send_cmd({CMD_DATA, 2'($urandom), 1'($urandom), 1'($urandom), 1'b1,
                    1'($urandom)});
          repeat ($urandom_range(1, 9)) begin
            if ($urandom_range(0, 7) == 0) send_key(SLOT_W'($urandom), BYTE_W'($urandom));
            send_read($urandom_range(0, 9) == 0);
          end
        end
        3: repeat ($urandom_range(1, 6)) send_fetch(ADDR_W'($urandom));
        4: send_cmd({($urandom_range(0, 1) == 1) ? CMD_DISP : CMD_MODE, 6'($urandom)});
        default: begin
          if ($urandom_range(0, 40) == 0) begin
            wait_for_results();
          end else begin
            repeat ($urandom_range(1, 4))
              send_beat(FUNC_W'($urandom), 1'($urandom), BYTE_W'($urandom),
                        SLOT_W'($urandom), ADDR_W'($urandom));
          end
        end
      endcase
    end
  endtask

  // result side
  initial begin
    port_result_t got;
    int idle;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      idle = draw_idle(recv_run_left, recv_quiet);
      if (idle > 0) begin
        out_stall <= 1'b1;
        repeat (idle) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.read_data = read_data;
      got.ram_write = ram_write;
      got.ram_address = ram_address;
      got.ram_data = ram_data;
      got.display_enabled = display_enabled;
      got.brightness = brightness;
      got.display_mode = display_mode;
      got.test_mode = test_mode;
      scoreboard.check_beat(got);
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FUNC_WRITE;
    frame_start <= 1'b0;
    byte_value <= '0;
    key_slot <= '0;
    fetch_address <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // mode and display commands at their extremes
    send_cmd({CMD_MODE, 6'h0F});
    send_cmd({CMD_DISP, 6'h0F});
    // key loads: first slot, last slot, and a slot past the key bytes
    send_key(3'd0, 8'hA5);
    send_key(3'd5, 8'hFF);
    send_key(3'd7, 8'h11);
    // key read with test set: reads run past the stored bytes and saturate
    send_cmd({CMD_DATA, 6'h0A});
    repeat (9) send_read(1'b0);
    send_read(1'b1);
    // plain data mode, then a data byte and a read outside any frame
    send_cmd({CMD_DATA, 6'h00});
    send_data(8'h33);
    send_read(1'b0);
    // last ram entry, a write above the ram, then wrap from the top
    send_cmd({CMD_ADDR, 6'd47});
    send_data(8'hFF);
    send_data(8'h5A);
    send_cmd({CMD_ADDR, 6'd63});
    send_data(8'h77);
    send_data(8'h00);
    // fixed addressing keeps writing the same entry
    send_cmd({CMD_DATA, 6'h04});
    send_cmd({CMD_ADDR, 6'd5});
    send_data(8'h12);
    send_data(8'h34);
    // fetches inside and above the ram
    send_fetch(6'd0);
    send_fetch(6'd47);
    send_fetch(6'd48);
    send_fetch(6'd63);
    send_cmd({CMD_MODE, 6'h00});
    send_cmd({CMD_DISP, 6'h00});

    run_random(975);
    wait_for_results();
    run_random(975);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (scoreboard.mismatch_count == 0 && scoreboard.pending_results.size() == 0) begin
      $display("tb_vfd_controller_command_interface_unit: PASS");
    end else begin
      $display("tb_vfd_controller_command_interface_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/vcci_pkg.sv
hw/rtl/vcci_ram.sv
hw/rtl/vcci_front.sv
hw/rtl/vcci_queue.sv
hw/rtl/vcci_back.sv
hw/rtl/vfd_controller_command_interface_unit.sv
hw/rtl/vcci_checker.sv
verif/tb_vfd_controller_command_interface_unit.sv
